### rtl/core/imut_pkg.sv
// ----------------------------------------------------------------------------
// IMU tilt package
// Shared item and handshake types, constants and the arctangent table.
// ----------------------------------------------------------------------------
package imut_pkg;

  localparam int CNT_W       = 7;
  localparam int ATAN_STEPS  = 23;
  localparam int ROOT_STEPS  = 31;
  localparam int RATE_SHIFT  = 28;
  // Reciprocal of 164 scaled by 2^28, rounded up, times the factor of ten.
  localparam int RATE_RECIP  = (2 ** RATE_SHIFT + 163) / 164;
  localparam int RATE_K      = 10 * RATE_RECIP;
  localparam int DEG90_Q16   = 90 * 65536;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               cal;
    logic               last;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] mag;
    logic [32:0] ssq;
  } ang_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [6:0] deg;
  } ang_rsp_t;

  // Arctangent of 2^-i in degrees, Q16.
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/imu_offset_calibration_and_tilt_top.sv
// A calibration sample is summed in the back end; the last one adds five
// offset divisions by reciprocal multiply, each a load state and a divide state.
// A run sample passes the difference and multiply states and then two angle
// passes (a start, 31 square root steps, CORDIC vectoring, a done state).
// The shared angle unit and a full output register hold the next sample back.
// Synchronous reset clears calibration; the first CAL_SAMPLES samples recalibrate.
// ----------------------------------------------------------------------------
// IMU offset calibration and tilt
// Gyro bias removal, rate scaling and accelerometer roll and pitch angles.
// ----------------------------------------------------------------------------
module imu_offset_calibration_and_tilt_top import imut_pkg::*; #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] gyro_x_raw,
  input  logic signed [15:0] gyro_y_raw,
  input  logic signed [15:0] gyro_z_raw,
  input  logic signed [15:0] accel_x_raw,
  input  logic signed [15:0] accel_y_raw,
  input  logic signed [15:0] accel_z_raw,
  output logic               empty,
  input  logic               pop,
  output logic signed [12:0] pitch_rate_dps,
  output logic signed [12:0] roll_rate_dps,
  output logic signed [12:0] yaw_rate_dps,
  output logic signed [7:0]  roll_deg,
  output logic signed [7:0]  pitch_deg
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_wr_item;
  item_t q_rd_item;

  imut_front #(.CAL_SAMPLES(CAL_SAMPLES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .gyro_x_raw  (gyro_x_raw),
    .gyro_y_raw  (gyro_y_raw),
    .gyro_z_raw  (gyro_z_raw),
    .accel_x_raw (accel_x_raw),
    .accel_y_raw (accel_y_raw),
    .accel_z_raw (accel_z_raw),
    .q_push      (q_push),
    .q_item      (q_wr_item),
    .q_full      (q_full)
  );

  imut_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_item),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_item),
    .empty   (q_empty)
  );

  imut_back #(.CAL_SAMPLES(CAL_SAMPLES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_item         (q_rd_item),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .pitch_rate_dps (pitch_rate_dps),
    .roll_rate_dps  (roll_rate_dps),
    .yaw_rate_dps   (yaw_rate_dps),
    .roll_deg       (roll_deg),
    .pitch_deg      (pitch_deg)
  );

endmodule

### rtl/core/imut_front.sv
// ----------------------------------------------------------------------------
// IMU tilt front end
// Accepts samples, marks calibration samples and forwards them to the queue.
// ----------------------------------------------------------------------------
module imut_front import imut_pkg::*; #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] gyro_x_raw,
  input  logic signed [15:0] gyro_y_raw,
  input  logic signed [15:0] gyro_z_raw,
  input  logic signed [15:0] accel_x_raw,
  input  logic signed [15:0] accel_y_raw,
  input  logic signed [15:0] accel_z_raw,
  output logic               q_push,
  output item_t              q_item,
  input  logic               q_full
);

  localparam logic [CNT_W-1:0] CAL_CNT = CNT_W'(CAL_SAMPLES);

  logic [CNT_W-1:0] cal_count;
  logic             calibrated;
  logic             last;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign last   = !calibrated && ((cal_count + CNT_W'(1)) == CAL_CNT);

  always_comb begin
    q_item.gx   = gyro_x_raw;
    q_item.gy   = gyro_y_raw;
    q_item.gz   = gyro_z_raw;
    q_item.ax   = accel_x_raw;
    q_item.ay   = accel_y_raw;
    q_item.az   = accel_z_raw;
    q_item.cal  = !calibrated;
    q_item.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count  <= '0;
      calibrated <= 1'b0;
    end else if (q_push && !calibrated) begin
      cal_count <= cal_count + CNT_W'(1);
      if (last) begin
        calibrated <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/imut_fifo.sv
// ----------------------------------------------------------------------------
// IMU tilt request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module imut_fifo import imut_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd,
  output item_t rd_data,
  output logic  empty
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/imut_angle.sv
// ----------------------------------------------------------------------------
// IMU tilt angle unit
// Bit-serial square root followed by iterative CORDIC vectoring, whole degrees.
// ----------------------------------------------------------------------------
module imut_angle import imut_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ang_req_t req,
  output ang_rsp_t rsp
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_SQRT = 2'd1;
  localparam logic [1:0] A_CORD = 2'd2;
  localparam logic [1:0] A_DONE = 2'd3;

  logic [1:0]         state;
  logic [4:0]         cnt;
  logic [61:0]        n;
  logic [32:0]        rem;
  logic [30:0]        root;
  logic [33:0]        x;
  logic signed [33:0] y;
  logic signed [24:0] z;
  logic [6:0]         deg;

  logic [32:0]        rem_t;
  logic [32:0]        trial;
  logic               take;
  logic [30:0]        root_next;
  logic [33:0]        yabs;
  logic [33:0]        xs;
  logic [33:0]        ys;
  logic [24:0]        atan_v;
  logic [6:0]         deg_z;

  always_comb begin
    rem_t     = {rem[30:0], n[61:60]};
    trial     = {root, 2'b01};
    take      = (rem_t >= trial);
    root_next = {root[29:0], take};
    yabs      = y[33] ? 34'(-y) : 34'(y);
    xs        = x >> cnt;
    ys        = yabs >> cnt;
    atan_v    = 25'(atan_q16(cnt));
    if (z < 0) begin
      deg_z = 7'd0;
    end else if (z > 25'(DEG90_Q16)) begin
      deg_z = 7'd90;
    end else begin
      deg_z = z[22:16];
    end
  end

  assign rsp.busy = (state != A_IDLE);
  assign rsp.done = (state == A_DONE);
  assign rsp.deg  = deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            if (req.mag == 16'd0) begin
              deg   <= 7'd0;
              state <= A_DONE;
            end else if (req.ssq == 33'd0) begin
              deg   <= 7'd90;
              state <= A_DONE;
            end else begin
              n     <= {1'b0, req.ssq, 28'd0};
              rem   <= '0;
              root  <= '0;
              cnt   <= '0;
              y     <= 34'({req.mag, 14'd0});
              state <= A_SQRT;
            end
          end
        end
        A_SQRT: begin
          rem  <= take ? rem_t - trial : rem_t;
          root <= root_next;
          n    <= {n[59:0], 2'b00};
          if (cnt == 5'(ROOT_STEPS - 1)) begin
            x     <= 34'(root_next);
            z     <= '0;
            cnt   <= '0;
            state <= A_CORD;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        A_CORD: begin
          if (y == 0 || cnt == 5'(ATAN_STEPS)) begin
            deg   <= deg_z;
            state <= A_DONE;
          end else begin
            x   <= x + ys;
            cnt <= cnt + 5'd1;
            if (y > 0) begin
              y <= y - $signed(xs);
              z <= z + $signed(atan_v);
            end else begin
              y <= y + $signed(xs);
              z <= z - $signed(atan_v);
            end
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == A_IDLE)
    else $error("angle request while the unit is busy");

  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.deg <= 7'd90)
    else $error("angle result above ninety degrees");

  a_sqrt_flow: assert property (@(posedge clk) disable iff (rst)
    state == A_SQRT |=> state == A_SQRT || state == A_CORD)
    else $error("square root left early");

endmodule

### rtl/core/imut_back.sv
// ----------------------------------------------------------------------------
// IMU tilt back end
// Accumulates calibration sums, derives offsets, computes rates and angles.
// ----------------------------------------------------------------------------
module imut_back import imut_pkg::*; #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  item_t              q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [12:0] pitch_rate_dps,
  output logic signed [12:0] roll_rate_dps,
  output logic signed [12:0] yaw_rate_dps,
  output logic signed [7:0]  roll_deg,
  output logic signed [7:0]  pitch_deg
);

  // Sums stay below 2^22 in magnitude, so a 2^29 scaled reciprocal rounded up
  // gives the exact truncated quotient for any sample count up to 127.
  localparam int          CAL_SHIFT = 29;
  localparam logic [29:0] CAL_RECIP =
    30'((2 ** CAL_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DLOAD = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ROLL  = 3'd5;
  localparam logic [2:0] S_PITCH = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]         state;
  item_t              item;
  logic signed [23:0] sums [5];
  logic signed [15:0] offsets [5];
  logic [2:0]         idx;
  logic [23:0]        dvd;
  logic               dneg_s;

  logic [15:0]        dmag [3];
  logic               dneg [3];
  logic [15:0]        amx;
  logic [15:0]        amy;
  logic [15:0]        amz;
  logic               axpos;
  logic               ayneg;
  logic signed [12:0] rate [3];
  logic [31:0]        sx;
  logic [31:0]        sy;
  logic [31:0]        sz;
  logic signed [7:0]  roll;
  logic signed [7:0]  pitch;
  logic               ang_start;
  logic               out_valid;

  logic signed [15:0] raw [5];
  logic [53:0]        oprod;
  logic [15:0]        oquot;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] dz;
  ang_req_t           areq;
  ang_rsp_t           arsp;

  assign raw[0] = item.gx;
  assign raw[1] = item.gy;
  assign raw[2] = item.gz;
  assign raw[3] = item.ax;
  assign raw[4] = item.ay;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_comb begin
    oprod = 54'(dvd) * 54'(CAL_RECIP);
    oquot = oprod[CAL_SHIFT+15:CAL_SHIFT];
    dx    = {raw[3][15], raw[3]} - {offsets[3][15], offsets[3]};
    dy    = {raw[4][15], raw[4]} - {offsets[4][15], offsets[4]};
    dz    = {item.az[15], item.az};
    areq.start = ang_start;
    if (state == S_ROLL) begin
      areq.mag = amy;
      areq.ssq = {1'b0, sx} + {1'b0, sz};
    end else begin
      areq.mag = amx;
      areq.ssq = {1'b0, sy} + {1'b0, sz};
    end
  end

  imut_angle u_angle (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ang_start <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      for (int k = 0; k < 5; k++) begin
        sums[k]    <= '0;
        offsets[k] <= '0;
      end
    end else begin
      ang_start <= 1'b0;
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= q_item.cal ? (q_item.last ? S_DLOAD : S_IDLE) : S_DIFF;
            idx   <= '0;
            if (q_item.cal) begin
              sums[0] <= sums[0] + 24'(q_item.gx);
              sums[1] <= sums[1] + 24'(q_item.gy);
              sums[2] <= sums[2] + 24'(q_item.gz);
              sums[3] <= sums[3] + 24'(q_item.ax);
              sums[4] <= sums[4] + 24'(q_item.ay);
            end
          end
        end
        S_DLOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          offsets[idx] <= dneg_s ? -oquot : oquot;
          if (idx == 3'd4) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_DLOAD;
          end
        end
        S_DIFF: begin
          state <= S_MUL;
        end
        S_MUL: begin
          ang_start <= 1'b1;
          state     <= S_ROLL;
        end
        S_ROLL: begin
          if (arsp.done) begin
            ang_start <= 1'b1;
            state     <= S_PITCH;
          end
        end
        S_PITCH: begin
          if (arsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && !q_empty) begin
      item <= q_item;
    end
    if (state == S_DLOAD) begin
      dneg_s <= sums[idx][23];
      dvd    <= sums[idx][23] ? 24'(-sums[idx]) : 24'(sums[idx]);
    end
    if (state == S_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [16:0] d;
        d       = {raw[k][15], raw[k]} - {offsets[k][15], offsets[k]};
        dneg[k] <= d[16];
        dmag[k] <= d[16] ? 16'(-d) : 16'(d);
      end
      amx   <= dx[16] ? 16'(-dx) : 16'(dx);
      amy   <= dy[16] ? 16'(-dy) : 16'(dy);
      amz   <= dz[16] ? 16'(-dz) : 16'(dz);
      axpos <= (dx > 0);
      ayneg <= dy[16];
    end
    if (state == S_MUL) begin
      for (int k = 0; k < 3; k++) begin
        logic [39:0] prod;
        prod    = {24'd0, dmag[k]} * 40'(RATE_K);
        rate[k] <= dneg[k] ? -13'(prod[39:RATE_SHIFT]) : 13'(prod[39:RATE_SHIFT]);
      end
      sx <= amx * amx;
      sy <= amy * amy;
      sz <= amz * amz;
    end
    if (state == S_ROLL && arsp.done) begin
      roll <= ayneg ? -8'(arsp.deg) : 8'(arsp.deg);
    end
    if (state == S_PITCH && arsp.done) begin
      pitch <= axpos ? -8'(arsp.deg) : 8'(arsp.deg);
    end
    if (state == S_OUT && !out_valid) begin
      pitch_rate_dps <= rate[0];
      roll_rate_dps  <= rate[1];
      yaw_rate_dps   <= rate[2];
      roll_deg       <= roll;
      pitch_deg      <= pitch;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue read outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !pop) |=> out_valid)
    else $error("result lost before it was taken");

  a_angle_done: assert property (@(posedge clk) disable iff (rst)
    arsp.done |-> state == S_ROLL || state == S_PITCH)
    else $error("angle result with no angle pending");

endmodule
